// ===== hw/rtl/shbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbm_pkg
// Shared constants, types and helpers of the sliding Hamming best-match unit.
// ----------------------------------------------------------------------------
package shbm_pkg;

    // Sizing
    localparam int MAX_PATTERN = 64;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 7;

    // Command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_GENOME = 1'b1;

    // Status codes
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_SHORT = 1'b1;

    // Compare stage handed from the window to the scorer
    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic                   full;
        logic                   too_short;
        logic [MAX_PATTERN-1:0] match;
    } t_s1;

    // Length in use: zero acts as one, large values clamp to the store depth
    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > LEN_W'(MAX_PATTERN)) begin
            r = CNT_W'(MAX_PATTERN);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/shbm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbm_in_if
// Input channel: pattern loads and genome symbols.
// ----------------------------------------------------------------------------
interface shbm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [shbm_pkg::IDX_W-1:0]    pattern_index;
    logic [shbm_pkg::SYM_W-1:0]    symbol;
    logic                          last;

    modport source (output valid, cmd, pattern_index, symbol, last, input ready);
    modport sink   (input valid, cmd, pattern_index, symbol, last, output ready);
endinterface

// ===== hw/rtl/shbm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbm_out_if
// Result channel: best match count and status.
// ----------------------------------------------------------------------------
interface shbm_out_if;
    logic                          valid;
    logic                          ready;
    logic [shbm_pkg::CNT_W-1:0]    best_count;
    logic                          status;

    modport source (output valid, best_count, status, input ready);
    modport sink   (input valid, best_count, status, output ready);
endinterface

// ===== hw/rtl/shbm_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbm_window
// Pattern store, genome shift window and per-position compare register.
// ----------------------------------------------------------------------------
module shbm_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    shbm_in_if.sink                     i_in,
    input  logic [shbm_pkg::CNT_W-1:0]  i_len,
    input  logic                        i_stall,
    output shbm_pkg::t_s1               o_s1
);
    import shbm_pkg::*;

    logic [SYM_W-1:0] r_pat [MAX_PATTERN];
    logic [SYM_W-1:0] r_win [MAX_PATTERN];
    logic [SYM_W-1:0] n_win [MAX_PATTERN];
    logic [CNT_W-1:0] r_seen;
    logic [CNT_W-1:0] n_seen;
    t_s1              r_s1;
    t_s1              n_s1;
    logic             accept;
    logic             gen_acc;

    assign i_in.ready = !i_stall;
    assign accept     = i_in.valid && i_in.ready;
    assign gen_acc    = accept && (i_in.cmd == CMD_GENOME);

    // Window after this symbol is shifted in (entry 0 newest)
    always_comb begin
        n_win[0] = i_in.symbol;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    // Saturating genome count
    assign n_seen = (r_seen < CNT_W'(MAX_PATTERN)) ? r_seen + CNT_W'(1) : r_seen;

    // Compare window (oldest first) against the pattern, lanes beyond len masked
    always_comb begin
        logic [CNT_W-1:0] pos;
        pos              = '0;
        n_s1.valid       = gen_acc;
        n_s1.last        = i_in.last;
        n_s1.full        = (n_seen >= i_len);
        n_s1.too_short   = (n_seen < i_len);
        for (int i = 0; i < MAX_PATTERN; i++) begin
            pos          = i_len - CNT_W'(i) - CNT_W'(1);
            n_s1.match[i] = (CNT_W'(i) < i_len) && (n_win[pos[IDX_W-1:0]] == r_pat[i]);
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (accept && (i_in.cmd == CMD_LOAD)) begin
            r_pat[i_in.pattern_index] <= i_in.symbol;
        end
        if (gen_acc) begin
            r_win <= n_win;
        end
    end

    // Control and compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= '0;
            r_s1     <= '0;
        end else begin
            if (gen_acc) begin
                r_seen <= i_in.last ? '0 : n_seen;
            end
            if (!i_stall) begin
                r_s1 <= n_s1;
            end
        end
    end

    assign o_s1 = r_s1;

`ifndef SYNTHESIS
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= CNT_W'(MAX_PATTERN))
        else $error("genome count beyond store depth");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gen_acc && i_in.last |=> r_seen == '0)
        else $error("genome count not cleared after last symbol");
    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.valid |-> (r_s1.full != r_s1.too_short))
        else $error("full and short flags disagree");
`endif

endmodule

// ===== hw/rtl/shbm_score.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbm_score
// Match popcount, running best and the result register.
// ----------------------------------------------------------------------------
module shbm_score (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  shbm_pkg::t_s1       i_s1,
    output logic                o_stall,
    shbm_out_if.source          o_out
);
    import shbm_pkg::*;

    logic [CNT_W-1:0] r_best;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cand;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_count;
    logic             r_out_status;
    logic             process;

    // Hold the compare stage only when a new result meets an untaken one
    assign o_stall = i_s1.valid && i_s1.last && r_out_valid && !o_out.ready;
    assign process = i_s1.valid && !o_stall;

    assign cnt  = CNT_W'($countones(i_s1.match));
    assign cand = (i_s1.full && (cnt > r_best)) ? cnt : r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (process) begin
                r_best <= i_s1.last ? '0 : cand;
            end
            if (process && i_s1.last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (process && i_s1.last) begin
            r_out_count  <= i_s1.too_short ? '0 : cand;
            r_out_status <= i_s1.too_short ? STAT_SHORT : STAT_OK;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.best_count = r_out_count;
    assign o_out.status     = r_out_status;

`ifndef SYNTHESIS
    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && i_s1.last |=> r_out_valid)
        else $error("last symbol produced no result");
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == STAT_SHORT) |-> r_out_count == '0)
        else $error("short genome with nonzero count");
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best <= CNT_W'(MAX_PATTERN))
        else $error("best count beyond pattern depth");
`endif

endmodule

// ===== hw/rtl/sliding_hamming_best_match_unit.sv =====
`timescale 1ns / 1ps
// A result goes out through the compare register and then the result register after
// its last genome symbol is accepted. Throughput: one item per cycle while input
// ready is high; the shift window, the per-lane compare and the 64-bit popcount
// each finish within one register stage. Input ready drops only while a result waits
// untaken and another last symbol sits in the compare stage. Reset clears the length
// (to 1), counts and valids; the pattern store holds no reset value until written.
// ----------------------------------------------------------------------------
// sliding_hamming_best_match_unit
// Loads a pattern, streams genome symbols and reports the best window match.
// ----------------------------------------------------------------------------
module sliding_hamming_best_match_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [shbm_pkg::LEN_W-1:0]  i_cfg_wdata,
    shbm_in_if.sink                     i_in,
    shbm_out_if.source                  o_out
);
    import shbm_pkg::*;

    logic [LEN_W-1:0] r_len;
    logic [CNT_W-1:0] len;
    t_s1              s1;
    logic             stall;

    // Pattern length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata;
        end
    end

    assign len = eff_len(r_len);

    shbm_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_len   (len),
        .i_stall (stall),
        .o_s1    (s1)
    );

    shbm_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .o_stall (stall),
        .o_out   (o_out)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sliding Hamming best-match unit: pattern loads, genome streams,
// best window score and short-genome status, under random stalls on both
// sides and a series of pattern lengths, extremes included.
// ----------------------------------------------------------------------------
module testbench;
    import shbm_pkg::*;

    localparam int unsigned ITEM_TARGET    = 1600;
    localparam int unsigned RESULT_TARGET  = 60;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned LONG_STALL     = 300;
    localparam int unsigned SETTLE_CYCLES  = 4;

    typedef struct {
        logic             cmd;
        logic [IDX_W-1:0] pattern_index;
        logic [SYM_W-1:0] symbol;
        logic             last;
        bit               wait_drain;
    } t_item;

    typedef struct {
        logic [CNT_W-1:0] best_count;
        logic             status;
    } t_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [LEN_W-1:0] i_cfg_wdata;

    shbm_in_if  in_if ();
    shbm_out_if out_if ();

    sliding_hamming_best_match_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Pending transactions and results still owed by the block
    t_item   stim_q[$];
    t_result best_match_q[$];

    // Scoring state, mirrors the block
    logic [SYM_W-1:0] pat_mem[MAX_PATTERN];
    logic [SYM_W-1:0] win_mem[MAX_PATTERN];
    logic [LEN_W-1:0] len_reg;
    int unsigned      genome_cnt;
    int unsigned      best_hits;

    // Stimulus side view of the pattern, used to shape genomes
    logic [SYM_W-1:0] gen_pat[MAX_PATTERN];
    bit               gen_loaded[MAX_PATTERN];
    int unsigned      gen_span;
    int unsigned      items_sent;
    int unsigned      results_planned;
    int unsigned      phase_cnt;

    // Handshake and idling control
    logic        in_took;
    bit          no_idle;
    int unsigned send_gap;
    int unsigned rdy_gap;
    int unsigned stall_left;
    int unsigned stall_requests;
    int unsigned stall_served;
    int unsigned idle_cycles;

    // Run statistics
    int unsigned fail_cnt;
    int unsigned loads_seen;
    int unsigned symbols_seen;
    int unsigned results_checked;
    int unsigned short_results;

    t_item   drv_item;
    t_item   acc_item;
    t_result want;

    always #2 i_clk = ~i_clk;

    function automatic int unsigned len_in_use(input logic [LEN_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_PATTERN) return MAX_PATTERN;
        return int'(v);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Nucleotide letters most of the time, any byte otherwise
    function automatic logic [SYM_W-1:0] base_symbol();
        case ($urandom_range(0, 4))
            0: return 8'h41;
            1: return 8'h43;
            2: return 8'h47;
            3: return 8'h54;
            default: return SYM_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic clear_search();
        for (int k = 0; k < MAX_PATTERN; k++) win_mem[k] = '0;
        genome_cnt = 0;
        best_hits  = 0;
    endtask

    // Apply one accepted transaction to the mirrored state
    task automatic score_item(input t_item it);
        int unsigned span;
        int unsigned hits;
        t_result     res;
        span = len_in_use(len_reg);
        if (it.cmd == CMD_LOAD) begin
            pat_mem[it.pattern_index] = it.symbol;
            loads_seen++;
        end else begin
            symbols_seen++;
            for (int k = MAX_PATTERN - 1; k > 0; k--) win_mem[k] = win_mem[k-1];
            win_mem[0] = it.symbol;
            if (genome_cnt < MAX_PATTERN) genome_cnt++;
            // window oldest first against pattern
            if (genome_cnt >= span) begin
                hits = 0;
                for (int k = 0; k < span; k++) begin
                    if (win_mem[span - 1 - k] == pat_mem[k]) hits++;
                end
                if (hits > best_hits) best_hits = hits;
            end
            if (it.last) begin
                if (genome_cnt < span) begin
                    res.best_count = '0;
                    res.status     = STAT_SHORT;
                end else begin
                    res.best_count = CNT_W'(best_hits);
                    res.status     = STAT_OK;
                end
                best_match_q.push_back(res);
                clear_search();
            end
        end
    endtask

    task automatic push_load(input int unsigned idx, input logic [SYM_W-1:0] s,
                             input logic lst);
        t_item it;
        it.cmd           = CMD_LOAD;
        it.pattern_index = IDX_W'(idx);
        it.symbol        = s;
        it.last          = lst;
        it.wait_drain    = 1'b0;
        stim_q.push_back(it);
        gen_pat[idx]    = s;
        gen_loaded[idx] = 1'b1;
        items_sent++;
    endtask

    task automatic push_genome(input logic [SYM_W-1:0] s, input logic lst,
                               input bit drain);
        t_item it;
        it.cmd           = CMD_GENOME;
        it.pattern_index = IDX_W'($urandom_range(0, MAX_PATTERN - 1));
        it.symbol        = s;
        it.last          = lst;
        it.wait_drain    = drain;
        stim_q.push_back(it);
        items_sent++;
        if (lst) results_planned++;
    endtask

    // Genome with pattern copies at a random phase, letters and noise mixed in
    task automatic push_search(input int unsigned n, input bit finish, input bit drain);
        int unsigned      off;
        int unsigned      r;
        logic [SYM_W-1:0] s;
        off = $urandom_range(0, gen_span - 1);
        for (int unsigned k = 0; k < n; k++) begin
            r = $urandom_range(0, 19);
            if (r < 11) s = gen_pat[(k + off) % gen_span];
            else if (r < 17) s = base_symbol();
            else s = SYM_W'($urandom_range(0, 255));
            // pattern rewrite in the middle of a genome
            if ($urandom_range(0, 40) == 0)
                push_load($urandom_range(0, gen_span - 1), base_symbol(),
                          logic'($urandom_range(0, 1)));
            push_genome(s, finish && (k == n - 1), drain && (k == 0));
        end
    endtask

    task automatic wait_idle();
        while (stim_q.size() != 0 || in_if.valid || best_match_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write with the block idle, then fill any unwritten pattern entry within the new length
    task automatic set_len(input logic [LEN_W-1:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gen_span = len_in_use(v);
        for (int k = 0; k < gen_span; k++) begin
            if (!gen_loaded[k]) push_load(k, base_symbol(), 1'b0);
        end
    endtask

    function automatic int unsigned pick_search_len();
        if (gen_span > 1 && $urandom_range(0, 6) == 0)
            return $urandom_range(1, gen_span - 1);
        return gen_span + $urandom_range(0, 20);
    endfunction

    // Driver: next transaction once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_took) begin
            if (send_gap > 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (stim_q.size() != 0 &&
                         !(stim_q[0].wait_drain && best_match_q.size() != 0)) begin
                drv_item = stim_q.pop_front();
                in_if.valid         <= 1'b1;
                in_if.cmd           <= drv_item.cmd;
                in_if.pattern_index <= drv_item.pattern_index;
                in_if.symbol        <= drv_item.symbol;
                in_if.last          <= drv_item.last;
                send_gap = no_idle ? 0 : pick_gap();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result ready: random gaps, requested long hold-offs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (stall_served < stall_requests) begin
            stall_served++;
            stall_left = LONG_STALL - 1;
            out_if.ready <= 1'b0;
        end else if (no_idle) begin
            out_if.ready <= 1'b1;
        end else if (rdy_gap > 0) begin
            rdy_gap--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rdy_gap = pick_gap();
        end
    end

    // Monitor: scoring of accepted transactions, result checks, watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_search();
            len_reg     = LEN_W'(1);
            idle_cycles = 0;
            in_took     <= 1'b0;
        end else begin
            in_took <= in_if.valid && in_if.ready;
            if (i_cfg_we) len_reg = i_cfg_wdata;
            if (in_if.valid && in_if.ready) begin
                acc_item.cmd           = in_if.cmd;
                acc_item.pattern_index = in_if.pattern_index;
                acc_item.symbol        = in_if.symbol;
                acc_item.last          = in_if.last;
                acc_item.wait_drain    = 1'b0;
                score_item(acc_item);
            end
            if (out_if.valid && out_if.ready) begin
                if (best_match_q.size() == 0) begin
                    $error("unexpected result: best_count %0d status %0d",
                           out_if.best_count, out_if.status);
                    fail_cnt++;
                end else begin
                    want = best_match_q.pop_front();
                    results_checked++;
                    if (want.status == STAT_SHORT) short_results++;
                    if (out_if.best_count !== want.best_count) begin
                        $error("best_count mismatch: expected %0d, actual %0d",
                               want.best_count, out_if.best_count);
                        fail_cnt++;
                    end
                    if (out_if.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, out_if.status);
                        fail_cnt++;
                    end
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        logic [LEN_W-1:0] len_val;
        int unsigned      searches;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        in_if.valid         = 1'b0;
        in_if.cmd           = CMD_LOAD;
        in_if.pattern_index = '0;
        in_if.symbol        = '0;
        in_if.last          = 1'b0;
        out_if.ready        = 1'b0;
        no_idle             = 1'b0;
        send_gap            = 0;
        rdy_gap             = 0;
        stall_left          = 0;
        stall_requests      = 0;
        stall_served        = 0;
        fail_cnt            = 0;
        items_sent          = 0;
        results_planned     = 0;
        phase_cnt           = 0;
        gen_span            = 1;
        for (int k = 0; k < MAX_PATTERN; k++) gen_loaded[k] = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Length one from reset, symbol extremes, last on a load is ignored
        push_load(0, 8'h00, 1'b0);
        push_genome(8'h00, 1'b1, 1'b0);
        push_genome(8'hFF, 1'b1, 1'b0);
        push_load(0, 8'hFF, 1'b1);
        push_genome(8'hFF, 1'b0, 1'b0);
        push_genome(8'h00, 1'b1, 1'b0);
        // Zero length acts as one
        set_len(LEN_W'(0));
        push_genome(8'hFF, 1'b1, 1'b0);
        // Genome shorter than pattern, then a full match and a miss
        push_load(1, 8'h00, 1'b0);
        set_len(LEN_W'(2));
        push_genome(8'hFF, 1'b1, 1'b0);
        push_genome(8'hFF, 1'b0, 1'b0);
        push_genome(8'h00, 1'b0, 1'b0);
        push_genome(8'hFF, 1'b1, 1'b0);
        push_load(MAX_PATTERN - 1, 8'hAA, 1'b0);
        // Largest register value clamps to the store depth: perfect match
        set_len(LEN_W'(127));
        for (int k = 0; k < MAX_PATTERN; k++)
            push_genome(gen_pat[k], k == MAX_PATTERN - 1, 1'b0);
        push_search(10, 1'b1, 1'b0);
        set_len(LEN_W'(MAX_PATTERN + 1));
        push_search(MAX_PATTERN + 6, 1'b1, 1'b0);

        // Random phases, each with its own length and idling mode
        while (items_sent < ITEM_TARGET || results_planned < RESULT_TARGET) begin
            phase_cnt++;
            case ($urandom_range(0, 11))
                0:       len_val = LEN_W'(0);
                1:       len_val = LEN_W'(1);
                2:       len_val = LEN_W'(MAX_PATTERN);
                3:       len_val = LEN_W'($urandom_range(MAX_PATTERN + 1, 127));
                4:       len_val = LEN_W'($urandom_range(13, MAX_PATTERN - 1));
                default: len_val = LEN_W'($urandom_range(2, 12));
            endcase
            if (phase_cnt == 4) len_val = LEN_W'(3);
            set_len(len_val);
            no_idle = ($urandom_range(0, 5) == 0);

            // fresh pattern now and then, plus stray loads anywhere in the store
            if ($urandom_range(0, 3) == 0) begin
                for (int k = 0; k < gen_span; k++)
                    push_load(k, base_symbol(), logic'($urandom_range(0, 7) == 0));
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6))
                    push_load($urandom_range(0, MAX_PATTERN - 1),
                              SYM_W'($urandom_range(0, 255)),
                              logic'($urandom_range(0, 1)));
            end

            if (phase_cnt == 4) begin
                // receiver holds off while many short searches back up
                stall_requests++;
                repeat (25) push_search(4, 1'b1, 1'b0);
            end else begin
                searches = (gen_span > 24) ? $urandom_range(1, 2) : $urandom_range(2, 6);
                for (int unsigned s = 0; s < searches; s++)
                    push_search(pick_search_len(), 1'b1,
                                s == 1 && $urandom_range(0, 3) == 0);
            end
            // unfinished genome carried over into the next length
            if ($urandom_range(0, 3) == 0)
                push_search($urandom_range(1, gen_span + 4), 1'b0, 1'b0);
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        $display("Covered %0d pattern loads and %0d genome symbols in %0d random phases;",
                 loads_seen, symbols_seen, phase_cnt);
        $display("%0d results checked, %0d of them for a genome shorter than the pattern.",
                 results_checked, short_results);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
